// ----- rtl/core/khist_pkg.sv -----
// ----------------------------------------------------------------------------
// khist_pkg: shared types and constants of the weighted colour histogram
// Bin geometry, fixed-point widths, register codes and the transaction types
// passed between the front, the queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package khist_pkg;

   // histogram geometry
   localparam int BINS_PER_CHANNEL = 16;
   localparam int CHAN_BITS        = $clog2(BINS_PER_CHANNEL);
   localparam int BIN_IDX_W        = 3 * CHAN_BITS;
   localparam int NUM_BINS         = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;

   // fixed-point widths
   localparam int COORD_W    = 9;
   localparam int COLOUR_W   = 8;
   localparam int HALF_W     = 16;
   localparam int INV_W      = 25;
   localparam int NORM_W     = 32;
   localparam int ACC_W      = 32;
   localparam int WEIGHT_W   = 17;
   localparam int OFFSET_W   = COORD_W + 8;
   localparam int SQUARE_W   = 2 * OFFSET_W;
   localparam int SPLIT_W    = SQUARE_W / 2;
   localparam int PART_W     = SPLIT_W + INV_W;
   localparam int AXIS_SUM_W = PART_W + SPLIT_W + 1;
   localparam int DIST_W     = AXIS_SUM_W + 1;
   localparam int ONE_POS    = 40;
   localparam int VALUE_W    = 25;
   localparam int PROD_W     = ACC_W + NORM_W;

   localparam logic [DIST_W-1:0]  DIST_ONE  = DIST_W'(1) << ONE_POS;
   localparam logic [VALUE_W-1:0] VALUE_ONE = VALUE_W'(1) << 24;

   // queue depths
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // transaction kinds
   typedef enum logic {
      MODE_ACCUM = 1'b0,
      MODE_READ  = 1'b1
   } mode_type;

   // register codes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_WIDTH   = 3'd0,
      CSR_HALF_HEIGHT  = 3'd1,
      CSR_INV_WIDTH_SQ = 3'd2,
      CSR_INV_HEIGHT_SQ= 3'd3,
      CSR_NORM_SCALE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [HALF_W-1:0] half_width;
      logic [HALF_W-1:0] half_height;
      logic [INV_W-1:0]  inv_half_width_sq;
      logic [INV_W-1:0]  inv_half_height_sq;
      logic [NORM_W-1:0] norm_scale;
   } cfg_type;

   // one classified transaction on its way to the bin store
   typedef struct packed {
      mode_type              mode;
      logic [BIN_IDX_W-1:0]  index;
      logic [WEIGHT_W-1:0]   weight;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic clearing;
      logic q_pop;
   } back_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/khist_front.sv -----
// ----------------------------------------------------------------------------
// khist_front: kernel distance and bin classification
// Five-stage pipeline: offsets, squares, split products with the inverse
// squares, per-axis sums, then the ellipse test and Epanechnikov weight.
// ----------------------------------------------------------------------------
`default_nettype none

module khist_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic                           req_mode,
   input  wire logic [khist_pkg::COORD_W-1:0]  req_pixel_col,
   input  wire logic [khist_pkg::COORD_W-1:0]  req_pixel_row,
   input  wire logic [khist_pkg::COLOUR_W-1:0] req_blue,
   input  wire logic [khist_pkg::COLOUR_W-1:0] req_green,
   input  wire logic [khist_pkg::COLOUR_W-1:0] req_red,
   input  wire logic [khist_pkg::BIN_IDX_W-1:0] req_read_index,
   input  wire khist_pkg::cfg_type             cfg,
   input  wire logic                           q_full,
   output logic                                stall,
   output logic                                q_push,
   output khist_pkg::item_type                 q_item
);
   import khist_pkg::*;

   logic                    en;

   // stage 1: absolute offsets from the centre
   logic                    v1_ff, v1_in;
   mode_type                mode1_ff;
   logic [BIN_IDX_W-1:0]    idx1_ff, idx1_in;
   logic [OFFSET_W-1:0]     adx1_ff, adx1_in, ady1_ff, ady1_in;
   logic signed [OFFSET_W:0] dx, dy;

   // stage 2: squares
   logic                    v2_ff;
   mode_type                mode2_ff;
   logic [BIN_IDX_W-1:0]    idx2_ff;
   logic [SQUARE_W-1:0]     sx2_ff, sy2_ff;

   // stage 3: partial products
   logic                    v3_ff;
   mode_type                mode3_ff;
   logic [BIN_IDX_W-1:0]    idx3_ff;
   logic [PART_W-1:0]       pxl3_ff, pxh3_ff, pyl3_ff, pyh3_ff;

   // stage 4: per-axis sums
   logic                    v4_ff;
   mode_type                mode4_ff;
   logic [BIN_IDX_W-1:0]    idx4_ff;
   logic [AXIS_SUM_W-1:0]   sumx4_ff, sumx4_in, sumy4_ff, sumy4_in;

   // stage 5: distance test and weight
   logic                    v5_ff, v5_in;
   item_type                item5_ff, item5_in;
   logic [DIST_W-1:0]       norm_dist;
   logic [ONE_POS:0]        rest;

   // whole pipeline holds while a finished transaction waits for queue space
   assign en    = !(v5_ff && q_full);
   assign stall = !en;

   // offsets and bin index
   always_comb begin
      dx = $signed({1'b0, req_pixel_col, 8'b0}) - $signed({2'b0, cfg.half_width});
      dy = $signed({2'b0, cfg.half_height}) - $signed({1'b0, req_pixel_row, 8'b0});
      adx1_in = dx[OFFSET_W] ? OFFSET_W'(-dx) : dx[OFFSET_W-1:0];
      ady1_in = dy[OFFSET_W] ? OFFSET_W'(-dy) : dy[OFFSET_W-1:0];
      if (mode_type'(req_mode) == MODE_READ) begin
         idx1_in = req_read_index;
      end else begin
         idx1_in = {req_blue[COLOUR_W-1 -: CHAN_BITS], req_green[COLOUR_W-1 -: CHAN_BITS],
                    req_red[COLOUR_W-1 -: CHAN_BITS]};
      end
      v1_in = accept;
   end

   // per-axis sums of the split products
   always_comb begin
      sumx4_in = {1'b0, pxh3_ff, SPLIT_W'(0)} + AXIS_SUM_W'(pxl3_ff);
      sumy4_in = {1'b0, pyh3_ff, SPLIT_W'(0)} + AXIS_SUM_W'(pyl3_ff);
   end

   // ellipse test and weight, reads pass through
   always_comb begin
      norm_dist = {1'b0, sumx4_ff} + {1'b0, sumy4_ff};
      rest      = DIST_ONE[ONE_POS:0] - norm_dist[ONE_POS:0];
      v5_in     = v4_ff && ((mode4_ff == MODE_READ) || (norm_dist <= DIST_ONE));
      item5_in.mode   = mode4_ff;
      item5_in.index  = idx4_ff;
      item5_in.weight = rest[ONE_POS -: WEIGHT_W];
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v5_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff <= mode_type'(req_mode);
         idx1_ff  <= idx1_in;
         adx1_ff  <= adx1_in;
         ady1_ff  <= ady1_in;

         mode2_ff <= mode1_ff;
         idx2_ff  <= idx1_ff;
         sx2_ff   <= adx1_ff * adx1_ff;
         sy2_ff   <= ady1_ff * ady1_ff;

         mode3_ff <= mode2_ff;
         idx3_ff  <= idx2_ff;
         pxl3_ff  <= sx2_ff[SPLIT_W-1:0] * cfg.inv_half_width_sq;
         pxh3_ff  <= sx2_ff[SQUARE_W-1:SPLIT_W] * cfg.inv_half_width_sq;
         pyl3_ff  <= sy2_ff[SPLIT_W-1:0] * cfg.inv_half_height_sq;
         pyh3_ff  <= sy2_ff[SQUARE_W-1:SPLIT_W] * cfg.inv_half_height_sq;

         mode4_ff <= mode3_ff;
         idx4_ff  <= idx3_ff;
         sumx4_ff <= sumx4_in;
         sumy4_ff <= sumy4_in;

         item5_ff <= item5_in;
      end
   end

   assign q_push = v5_ff && !q_full;
   assign q_item = item5_ff;

endmodule

`default_nettype wire

// ----- rtl/core/khist_queue.sv -----
// ----------------------------------------------------------------------------
// khist_queue: decoupling queue between front and back
// Small register queue of classified transactions; the head is always shown.
// ----------------------------------------------------------------------------
`default_nettype none

module khist_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire khist_pkg::item_type push_item,
   output logic                     full,
   input  wire logic                pop,
   output khist_pkg::head_type      head
);
   import khist_pkg::*;

   item_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- rtl/core/khist_back.sv -----
// ----------------------------------------------------------------------------
// khist_back: bin store, read-modify-write and readout
// Clears the store after reset, then takes one transaction a cycle from the
// queue when the result queue has room: registered read, saturating add or
// clear with write forwarding, and for reads a scaling multiply into it.
// ----------------------------------------------------------------------------
`default_nettype none

module khist_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire khist_pkg::head_type             q_head,
   output logic                                 q_pop,
   input  wire logic [khist_pkg::NORM_W-1:0]    norm_scale,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [khist_pkg::BIN_IDX_W-1:0]      rsp_bin_index,
   output logic [khist_pkg::VALUE_W-1:0]        rsp_bin_value,
   output khist_pkg::back_status_type           status
);
   import khist_pkg::*;

   logic                    en;

   // bin store
   logic [ACC_W-1:0]        mem [NUM_BINS];
   logic                    mem_we;
   logic [BIN_IDX_W-1:0]    mem_waddr;
   logic [ACC_W-1:0]        mem_wdata;
   logic [ACC_W-1:0]        rdata_ff;

   // clearing pass
   logic                    clearing_ff, clearing_in;
   logic [BIN_IDX_W-1:0]    clr_addr_ff, clr_addr_in;

   // execute stage and forwarding of the last write
   logic                    e_v_ff;
   item_type                e_item_ff;
   logic                    fwd_v_ff;
   logic [BIN_IDX_W-1:0]    fwd_idx_ff;
   logic [ACC_W-1:0]        fwd_data_ff;
   logic [ACC_W-1:0]        old_val;
   logic [ACC_W:0]          acc_sum;
   logic [ACC_W-1:0]        new_val;

   // scaling stage
   logic                    p_v_ff;
   logic [BIN_IDX_W-1:0]    p_idx_ff;
   logic [PROD_W-1:0]       p_prod_ff;
   logic [PROD_W-25:0]      scaled;
   logic [VALUE_W-1:0]      value;

   // result queue
   logic [BIN_IDX_W-1:0]    of_idx_ff [QUEUE_DEPTH];
   logic [VALUE_W-1:0]      of_val_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       of_wr_ff, of_rd_ff;
   logic [QCNT_W-1:0]       of_cnt_ff;
   logic                    of_push, of_pop, of_room;

   // back end holds only when a result cannot enter the result queue
   assign of_pop  = rsp_pop && !rsp_empty;
   assign of_room = (of_cnt_ff != QCNT_W'(QUEUE_DEPTH)) || of_pop;
   assign en      = !(p_v_ff && !of_room);
   assign q_pop   = en && q_head.valid && !clearing_ff;
   assign of_push = en && p_v_ff;

   // clearing pass sequencing
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + BIN_IDX_W'(1);
         if (clr_addr_ff == BIN_IDX_W'(NUM_BINS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // read-modify-write with forwarding of the previous write
   always_comb begin
      old_val = (fwd_v_ff && (fwd_idx_ff == e_item_ff.index)) ? fwd_data_ff : rdata_ff;
      acc_sum = {1'b0, old_val} + (ACC_W+1)'(e_item_ff.weight);
      if (e_item_ff.mode == MODE_READ) begin
         new_val = '0;
      end else begin
         new_val = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
      end
   end

   // store write port: clearing pass or execute stage
   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = en && e_v_ff;
         mem_waddr = e_item_ff.index;
         mem_wdata = new_val;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rdata_ff <= mem[q_head.item.index];
      end
   end

   // control of the execute and scaling stages
   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff   <= 1'b0;
         fwd_v_ff <= 1'b0;
         p_v_ff   <= 1'b0;
      end else if (en) begin
         e_v_ff   <= q_pop;
         fwd_v_ff <= e_v_ff;
         p_v_ff   <= e_v_ff && (e_item_ff.mode == MODE_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (q_pop) begin
            e_item_ff <= q_head.item;
         end
         fwd_idx_ff  <= e_item_ff.index;
         fwd_data_ff <= new_val;
         p_idx_ff    <= e_item_ff.index;
         p_prod_ff   <= old_val * norm_scale;
      end
   end

   // scale back to Q1.24 and limit to one
   always_comb begin
      scaled = p_prod_ff[PROD_W-1:24];
      if (scaled > (PROD_W-24)'(VALUE_ONE)) begin
         value = VALUE_ONE;
      end else begin
         value = scaled[VALUE_W-1:0];
      end
   end

   // result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         of_wr_ff  <= '0;
         of_rd_ff  <= '0;
         of_cnt_ff <= '0;
      end else begin
         if (of_push) begin
            of_wr_ff <= of_wr_ff + QPTR_W'(1);
         end
         if (of_pop) begin
            of_rd_ff <= of_rd_ff + QPTR_W'(1);
         end
         of_cnt_ff <= of_cnt_ff + QCNT_W'(of_push) - QCNT_W'(of_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (of_push) begin
         of_idx_ff[of_wr_ff] <= p_idx_ff;
         of_val_ff[of_wr_ff] <= value;
      end
   end

   assign rsp_empty       = (of_cnt_ff == '0);
   assign rsp_bin_index   = of_idx_ff[of_rd_ff];
   assign rsp_bin_value   = of_val_ff[of_rd_ff];
   assign status.clearing = clearing_ff;
   assign status.q_pop    = q_pop;

endmodule

`default_nettype wire

// ----- rtl/core/kernel_weighted_color_histogram.sv -----
// ----------------------------------------------------------------------------
// kernel_weighted_color_histogram: Epanechnikov-weighted 16x16x16 RGB histogram
// Register file, front classification pipeline, decoupling queue and bin store.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-bin store to zero, one bin a cycle, and
// req_full stays high until it is done (register writes are taken during that
// time). Afterwards it takes one transaction per cycle when nothing stalls:
// pixel transactions go through a five-stage distance pipeline and then a
// read-modify-write of one bin, with the last write forwarded so that
// back-to-back pixels of the same bin add up correctly; read transactions
// return the bin scaled by norm_scale and clear it, the result going from the
// scaling stage into the result queue. The store has one read and one write
// port, each used at most once a cycle, which sets that rate. Pixels outside
// the unit ellipse leave no trace and produce no result.
`default_nettype none

module kernel_weighted_color_histogram (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic                            req_mode,
   input  wire logic [khist_pkg::COORD_W-1:0]   req_pixel_col,
   input  wire logic [khist_pkg::COORD_W-1:0]   req_pixel_row,
   input  wire logic [khist_pkg::COLOUR_W-1:0]  req_blue,
   input  wire logic [khist_pkg::COLOUR_W-1:0]  req_green,
   input  wire logic [khist_pkg::COLOUR_W-1:0]  req_red,
   input  wire logic [khist_pkg::BIN_IDX_W-1:0] req_read_index,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [khist_pkg::BIN_IDX_W-1:0]      rsp_bin_index,
   output logic [khist_pkg::VALUE_W-1:0]        rsp_bin_value,
   input  wire logic                            csr_we,
   input  wire logic [khist_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [khist_pkg::NORM_W-1:0]    csr_wdata
);
   import khist_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             accept;
   logic             front_stall;
   logic             q_push, q_full, q_pop;
   item_type         q_item;
   head_type         q_head;
   back_status_type  back_status;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HALF_WIDTH:    cfg_in.half_width         = csr_wdata[HALF_W-1:0];
            CSR_HALF_HEIGHT:   cfg_in.half_height        = csr_wdata[HALF_W-1:0];
            CSR_INV_WIDTH_SQ:  cfg_in.inv_half_width_sq  = csr_wdata[INV_W-1:0];
            CSR_INV_HEIGHT_SQ: cfg_in.inv_half_height_sq = csr_wdata[INV_W-1:0];
            CSR_NORM_SCALE:    cfg_in.norm_scale         = csr_wdata[NORM_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_width         <= HALF_W'(4096);
         cfg_ff.half_height        <= HALF_W'(4096);
         cfg_ff.inv_half_width_sq  <= INV_W'(65536);
         cfg_ff.inv_half_height_sq <= INV_W'(65536);
         cfg_ff.norm_scale         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input handshake
   assign req_full = reset || back_status.clearing || front_stall;
   assign accept   = req_push && !req_full;

   khist_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_mode       (req_mode),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .req_blue       (req_blue),
      .req_green      (req_green),
      .req_red        (req_red),
      .req_read_index (req_read_index),
      .cfg            (cfg_ff),
      .q_full         (q_full),
      .stall          (front_stall),
      .q_push         (q_push),
      .q_item         (q_item)
   );

   khist_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head)
   );

   khist_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .norm_scale    (cfg_ff.norm_scale),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_value (rsp_bin_value),
      .status        (back_status)
   );

`ifndef SYNTH
   // no result can appear while the store is still being cleared
   a_no_result_while_clearing : assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> rsp_empty)
      else $error("result queue not empty during clearing pass");

   // the back end only takes transactions that the queue holds
   a_pop_only_when_held : assert property (@(posedge clock) disable iff (reset)
      back_status.q_pop |-> q_head.valid)
      else $error("queue popped while empty");

   // the clearing pass blocks input straight after reset
   a_full_after_reset : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_full)
      else $error("input accepted before clearing pass");
`endif

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for kernel_weighted_color_histogram
// Feeds pixel and bin-readout transactions through the request queue port,
// keeps its own copy of the register file and of the 4096 weight bins, and
// compares every readout with the value that copy predicts. The run walks
// through several ellipse and scale settings, a full-weight run and all
// four idle/stall patterns on the two handshakes.
// ----------------------------------------------------------------------------

module tb;
   import khist_pkg::*;

   localparam int          CLK_HALF_NS      = 5;
   localparam int          RESET_CYCLES     = 5;
   localparam int          SETTLE_CYCLES    = 32;
   localparam longint      RUN_LIMIT_NS     = 500_000;
   localparam int          RANDOM_PER_PHASE = 70;
   localparam int          READ_PCT         = 25;
   localparam int          PALETTE_SIZE     = 8;
   localparam int          FULL_WEIGHT_PIXELS = 16;
   localparam int          ROI_LAST         = 2 ** COORD_W - 1;
   localparam int          WEIGHT_SHIFT     = ONE_POS - 16;
   localparam int          SCALE_SHIFT      = VALUE_W - 1;
   localparam logic [63:0] ONE_Q40          = 64'd1 << ONE_POS;
   localparam logic [NORM_W-1:0] UNIT_SCALE = NORM_W'(1) << SCALE_SHIFT;

   typedef struct {
      mode_type               mode;
      logic [COORD_W-1:0]     col;
      logic [COORD_W-1:0]     row;
      logic [COLOUR_W-1:0]    blue;
      logic [COLOUR_W-1:0]    green;
      logic [COLOUR_W-1:0]    red;
      logic [BIN_IDX_W-1:0]   read_index;
   } hist_txn_type;

   typedef struct packed {
      logic [BIN_IDX_W-1:0] index;
      logic [VALUE_W-1:0]   value;
   } bin_readout_type;

   // block ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic                   req_mode = 1'b0;
   logic [COORD_W-1:0]     req_pixel_col = '0;
   logic [COORD_W-1:0]     req_pixel_row = '0;
   logic [COLOUR_W-1:0]    req_blue = '0;
   logic [COLOUR_W-1:0]    req_green = '0;
   logic [COLOUR_W-1:0]    req_red = '0;
   logic [BIN_IDX_W-1:0]   req_read_index = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [BIN_IDX_W-1:0]   rsp_bin_index;
   logic [VALUE_W-1:0]     rsp_bin_value;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [NORM_W-1:0]      csr_wdata = '0;

   // bench copy of the register file and of the bin store
   logic [HALF_W-1:0]      half_width_q = 16'd4096;
   logic [HALF_W-1:0]      half_height_q = 16'd4096;
   logic [INV_W-1:0]       inv_width_sq_q = 25'd65536;
   logic [INV_W-1:0]       inv_height_sq_q = 25'd65536;
   logic [NORM_W-1:0]      norm_scale_q = '0;
   logic [ACC_W-1:0]       bin_weights [NUM_BINS] = '{default: '0};

   hist_txn_type           txn_backlog [$];
   bin_readout_type        awaited_readouts [$];
   hist_txn_type           on_air;
   logic [BIN_IDX_W-1:0]   colour_palette [PALETTE_SIZE];
   int unsigned            send_idle_pct = 0;
   int unsigned            recv_stall_pct = 0;
   int                     mismatches = 0;
   int                     pixels_taken = 0;
   int                     readouts_taken = 0;
   int                     settings_count = 0;

   kernel_weighted_color_histogram u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .req_blue       (req_blue),
      .req_green      (req_green),
      .req_red        (req_red),
      .req_read_index (req_read_index),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_bin_value  (rsp_bin_value),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // clock
   initial begin
      forever #(CLK_HALF_NS) clock = ~clock;
   end

   // accumulate a pixel or read and clear a bin in the bench copy
   task automatic predict_histogram(input hist_txn_type t);
      longint               off_x;
      longint               off_y;
      logic [63:0]          mag_x;
      logic [63:0]          mag_y;
      logic [63:0]          ell_sum;
      logic [63:0]          weight;
      logic [63:0]          scaled;
      logic [ACC_W:0]       total;
      logic [BIN_IDX_W-1:0] bin;
      bin_readout_type      rd;
      if (t.mode == MODE_ACCUM) begin
         pixels_taken++;
         off_x = longint'({t.col, 8'h00}) - longint'(half_width_q);
         off_y = longint'(half_height_q) - longint'({t.row, 8'h00});
         mag_x = (off_x < 0) ? -off_x : off_x;
         mag_y = (off_y < 0) ? -off_y : off_y;
         ell_sum = mag_x * mag_x * inv_width_sq_q + mag_y * mag_y * inv_height_sq_q;
         // only pixels on or inside the unit ellipse contribute
         if (ell_sum <= ONE_Q40) begin
            weight = (ONE_Q40 - ell_sum) >> WEIGHT_SHIFT;
            bin    = {t.blue[COLOUR_W-1 -: CHAN_BITS], t.green[COLOUR_W-1 -: CHAN_BITS],
                      t.red[COLOUR_W-1 -: CHAN_BITS]};
            total  = {1'b0, bin_weights[bin]} + weight[ACC_W:0];
            bin_weights[bin] = total[ACC_W] ? '1 : total[ACC_W-1:0];
         end
      end else begin
         readouts_taken++;
         scaled = ({32'b0, bin_weights[t.read_index]} * {32'b0, norm_scale_q}) >> SCALE_SHIFT;
         if (scaled > 64'(VALUE_ONE))
            scaled = 64'(VALUE_ONE);
         rd.index = t.read_index;
         rd.value = scaled[VALUE_W-1:0];
         bin_weights[t.read_index] = '0;
         awaited_readouts.push_back(rd);
      end
   endtask

   // request driver: holds a pushed transaction until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full)
            predict_histogram(on_air);
         if (!req_push || !req_full) begin
            if (txn_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_air = txn_backlog.pop_front();
               req_mode       <= on_air.mode;
               req_pixel_col  <= on_air.col;
               req_pixel_row  <= on_air.row;
               req_blue       <= on_air.blue;
               req_green      <= on_air.green;
               req_red        <= on_air.red;
               req_read_index <= on_air.read_index;
               req_push       <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // readout monitor with random back-pressure
   always @(posedge clock) begin
      bin_readout_type exp_rd;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (awaited_readouts.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected readout, expected none, got bin %0d value %0d",
                        $time, rsp_bin_index, rsp_bin_value);
            end else begin
               exp_rd = awaited_readouts.pop_front();
               if (rsp_bin_index !== exp_rd.index) begin
                  mismatches++;
                  $display("%0t: bin_index expected %0d got %0d",
                           $time, exp_rd.index, rsp_bin_index);
               end
               if (rsp_bin_value !== exp_rd.value) begin
                  mismatches++;
                  $display("%0t: bin_value of bin %0d expected %0d got %0d",
                           $time, exp_rd.index, exp_rd.value, rsp_bin_value);
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // register write, mirrored into the bench copy
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [NORM_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_HALF_WIDTH:    half_width_q    = data[HALF_W-1:0];
         CSR_HALF_HEIGHT:   half_height_q   = data[HALF_W-1:0];
         CSR_INV_WIDTH_SQ:  inv_width_sq_q  = data[INV_W-1:0];
         CSR_INV_HEIGHT_SQ: inv_height_sq_q = data[INV_W-1:0];
         CSR_NORM_SCALE:    norm_scale_q    = data;
         default: ;
      endcase
   endtask

   // all registers, with junk above each field and a write to an unused index
   task automatic program_regs(input logic [HALF_W-1:0] hx, input logic [HALF_W-1:0] hy,
                               input logic [INV_W-1:0] iw, input logic [INV_W-1:0] ih,
                               input logic [NORM_W-1:0] norm);
      logic [NORM_W-1:0] pad;
      pad = $urandom; pad[HALF_W-1:0] = hx; write_reg(CSR_HALF_WIDTH, pad);
      pad = $urandom; pad[HALF_W-1:0] = hy; write_reg(CSR_HALF_HEIGHT, pad);
      pad = $urandom; pad[INV_W-1:0]  = iw; write_reg(CSR_INV_WIDTH_SQ, pad);
      pad = $urandom; pad[INV_W-1:0]  = ih; write_reg(CSR_INV_HEIGHT_SQ, pad);
      write_reg(CSR_NORM_SCALE, norm);
      write_reg(CSR_IDX_W'($urandom_range(2 ** CSR_IDX_W - 1, int'(CSR_NORM_SCALE) + 1)),
                $urandom);
      settings_count++;
   endtask

   // 1/h^2 in Q1.24 for a Q8.8 half axis
   function automatic logic [INV_W-1:0] inverse_square(input logic [HALF_W-1:0] h);
      logic [63:0] q;
      if (h == '0)
         return '1;
      q = ONE_Q40 / (64'(h) * 64'(h));
      if (q > 64'({INV_W{1'b1}}))
         q = 64'({INV_W{1'b1}});
      return q[INV_W-1:0];
   endfunction

   // wait until nothing is queued, pushed or awaited, then let pixels retire
   task automatic wait_drained();
      do
         @(negedge clock);
      while (txn_backlog.size() != 0 || req_push || awaited_readouts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic hist_txn_type make_pixel(input int col, input int row,
                                               input logic [COLOUR_W-1:0] b,
                                               input logic [COLOUR_W-1:0] g,
                                               input logic [COLOUR_W-1:0] r);
      hist_txn_type t;
      t.mode       = MODE_ACCUM;
      t.col        = COORD_W'(col);
      t.row        = COORD_W'(row);
      t.blue       = b;
      t.green      = g;
      t.red        = r;
      t.read_index = BIN_IDX_W'($urandom);
      return t;
   endfunction

   function automatic hist_txn_type make_read(input logic [BIN_IDX_W-1:0] idx);
      hist_txn_type t;
      t = make_pixel($urandom, $urandom, COLOUR_W'($urandom), COLOUR_W'($urandom),
                     COLOUR_W'($urandom));
      t.mode       = MODE_READ;
      t.read_index = idx;
      return t;
   endfunction

   // a position near the centre along one axis, reaching just past the ellipse
   function automatic logic [COORD_W-1:0] near_centre(input logic [HALF_W-1:0] half);
      int centre;
      int reach;
      int pos;
      centre = (int'(half) + 128) >> 8;
      reach  = (int'(half) >> 8) + 1;
      pos    = centre - reach + int'($urandom_range(2 * reach));
      if (pos < 0)
         pos = 0;
      if (pos > ROI_LAST)
         pos = ROI_LAST;
      return pos[COORD_W-1:0];
   endfunction

   // mostly pixels near the ellipse in a few bins, reads mostly of those bins
   function automatic hist_txn_type random_txn();
      hist_txn_type         t;
      logic [BIN_IDX_W-1:0] pick;
      t = make_pixel($urandom, $urandom, COLOUR_W'($urandom), COLOUR_W'($urandom),
                     COLOUR_W'($urandom));
      pick = colour_palette[$urandom_range(PALETTE_SIZE - 1)];
      if ($urandom_range(99) < READ_PCT) begin
         t.mode = MODE_READ;
         if ($urandom_range(99) < 80)
            t.read_index = pick;
      end else begin
         if ($urandom_range(99) < 85) begin
            t.col = near_centre(half_width_q);
            t.row = near_centre(half_height_q);
         end
         if ($urandom_range(99) < 90) begin
            t.blue[COLOUR_W-1 -: CHAN_BITS]  = pick[BIN_IDX_W-1 -: CHAN_BITS];
            t.green[COLOUR_W-1 -: CHAN_BITS] = pick[2*CHAN_BITS-1 -: CHAN_BITS];
            t.red[COLOUR_W-1 -: CHAN_BITS]   = pick[CHAN_BITS-1:0];
         end
      end
      return t;
   endfunction

   task automatic queue_random(input int count);
      @(negedge clock);
      repeat (count) txn_backlog.push_back(random_txn());
   endtask

   // one register setting, random traffic split by a full drain
   task automatic run_random_phase(input logic [HALF_W-1:0] hx, input logic [HALF_W-1:0] hy,
                                   input logic [INV_W-1:0] iw, input logic [INV_W-1:0] ih,
                                   input logic [NORM_W-1:0] norm,
                                   input int unsigned send_pct, input int unsigned recv_pct);
      program_regs(hx, hy, iw, ih, norm);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      foreach (colour_palette[i])
         colour_palette[i] = BIN_IDX_W'($urandom);
      queue_random(RANDOM_PER_PHASE / 2);
      wait_drained();
      queue_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
      wait_drained();
   endtask

   // stimulus sequence
   initial begin
      logic [BIN_IDX_W-1:0] full_bin;
      logic [HALF_W-1:0]    hx;
      logic [HALF_W-1:0]    hy;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: 16-pixel circle, unit scale so readouts show the raw sums
      program_regs(16'd4096, 16'd4096, 25'd65536, 25'd65536, UNIT_SCALE);
      @(negedge clock);
      txn_backlog.push_back(make_read('0));
      txn_backlog.push_back(make_pixel(16, 16, 8'h00, 8'h00, 8'h00));
      txn_backlog.push_back(make_pixel(16, 16, 8'h0F, 8'h0F, 8'h0F));
      txn_backlog.push_back(make_pixel(0, 16, 8'hFF, 8'hFF, 8'hFF));
      txn_backlog.push_back(make_pixel(32, 16, 8'hF0, 8'hF0, 8'hF0));
      txn_backlog.push_back(make_pixel(16, 0, 8'hFF, 8'hF5, 8'hFA));
      txn_backlog.push_back(make_pixel(16, 32, 8'hF3, 8'hFF, 8'hF0));
      txn_backlog.push_back(make_pixel(33, 16, 8'hFF, 8'hFF, 8'hFF));
      txn_backlog.push_back(make_pixel(ROI_LAST, ROI_LAST, 8'hFF, 8'hFF, 8'hFF));
      txn_backlog.push_back(make_pixel(0, 0, 8'h00, 8'h00, 8'h00));
      txn_backlog.push_back(make_pixel(20, 13, 8'h80, 8'h40, 8'h10));
      txn_backlog.push_back(make_pixel(20, 13, 8'h8F, 8'h4F, 8'h1F));
      txn_backlog.push_back(make_pixel(11, 19, 8'h5A, 8'hA5, 8'hC3));
      txn_backlog.push_back(make_read('0));
      txn_backlog.push_back(make_read('0));
      txn_backlog.push_back(make_read('1));
      txn_backlog.push_back(make_read(12'h841));
      txn_backlog.push_back(make_read(12'h5AC));
      txn_backlog.push_back(make_read(12'h841));
      wait_drained();

      // full weight: zero inverses give every pixel the weight of the centre
      program_regs(16'd4096, 16'd4096, '0, '0, NORM_W'(256));
      full_bin = BIN_IDX_W'($urandom);
      @(negedge clock);
      repeat (FULL_WEIGHT_PIXELS)
         txn_backlog.push_back(make_pixel($urandom, $urandom,
                                          {full_bin[11:8], 4'($urandom)},
                                          {full_bin[7:4], 4'($urandom)},
                                          {full_bin[3:0], 4'($urandom)}));
      txn_backlog.push_back(make_read(full_bin));
      txn_backlog.push_back(make_read(full_bin));
      wait_drained();

      // random traffic over several settings and idle patterns
      run_random_phase(16'd4096, 16'd4096, inverse_square(16'd4096), inverse_square(16'd4096),
                       $urandom, 0, 0);
      run_random_phase(16'd1408, 16'd10304, inverse_square(16'd1408),
                       inverse_square(16'd10304), UNIT_SCALE, 58, 0);
      hx = HALF_W'($urandom_range(12000, 256));
      hy = HALF_W'($urandom_range(12000, 256));
      run_random_phase(hx, hy, inverse_square(hx), inverse_square(hy), $urandom, 0, 58);
      run_random_phase(16'd256, 16'hFFFF, inverse_square(16'd256), inverse_square(16'hFFFF),
                       '1, 17, 17);
      run_random_phase('0, 16'hFFFF, '1, '0, '0, 58, 58);
      run_random_phase(16'hFFFF, '0, '0, '1, $urandom, 17, 17);

      $display("covered %0d pixel and %0d readout transactions over %0d register settings,",
               pixels_taken, readouts_taken, settings_count);
      $display("with full-weight pixels, edge-of-ellipse weights and zero and full-scale norms");
      if (mismatches == 0)
         $display("** kernel_weighted_color_histogram: PASSED **");
      else
         $display("** kernel_weighted_color_histogram: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d readouts outstanding", awaited_readouts.size());
      $display("** kernel_weighted_color_histogram: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/khist_pkg.sv
rtl/core/khist_front.sv
rtl/core/khist_queue.sv
rtl/core/khist_back.sv
rtl/core/kernel_weighted_color_histogram.sv
test/tb.sv
